FILE: design/frce_pkg.sv
package frce_pkg;

    localparam int MaxSide    = 256;
    localparam int PixelBits  = 24;
    localparam int CoordBits  = $clog2(MaxSide);
    localparam int SizeBits   = CoordBits + 1;
    localparam int AddrBits   = 2 * CoordBits + 1;
    localparam int StoreDepth = 2 * MaxSide * MaxSide;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_LOAD   = 3'd0;
    localparam cmd_t CMD_WRITE  = 3'd1;
    localparam cmd_t CMD_READ   = 3'd2;
    localparam cmd_t CMD_SELECT = 3'd3;
    localparam cmd_t CMD_SELALL = 3'd4;
    localparam cmd_t CMD_ROTATE = 3'd5;
    localparam cmd_t CMD_CROP   = 3'd6;
    localparam cmd_t CMD_NONE   = 3'd7;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_NO_IMAGE   = 3'd1;
    localparam status_t ST_BAD_COORD  = 3'd2;
    localparam status_t ST_NOT_SQUARE = 3'd3;
    localparam status_t ST_BAD_ANGLE  = 3'd4;

    // Copy pass kinds for the walker.
    typedef logic [1:0] pass_t;
    localparam pass_t PASS_TURN_WHOLE = 2'd0;
    localparam pass_t PASS_TURN_SUB   = 2'd1;
    localparam pass_t PASS_BACK_SUB   = 2'd2;
    localparam pass_t PASS_CROP       = 2'd3;

    typedef struct packed {
        logic                start;
        pass_t               kind;
        logic                src_bank;
        logic [SizeBits-1:0] rows;
        logic [SizeBits-1:0] cols;
        logic [SizeBits-1:0] x1;
        logic [SizeBits-1:0] y1;
        logic [SizeBits-1:0] w;
    } walk_ctl_t;

    function automatic logic [AddrBits-1:0] addr_of(logic bank, logic [SizeBits-1:0] x,
                                                   logic [SizeBits-1:0] y);
        return {bank, y[CoordBits-1:0], x[CoordBits-1:0]};
    endfunction

endpackage

FILE: design/frce_ram.sv
module frce_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/frce_walker.sv
// Walks one copy pass: one read address per cycle, each write lands in the cycle after its read.
module frce_walker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  frce_pkg::walk_ctl_t                    ctl,
    output logic                                   busy,
    output logic [frce_pkg::AddrBits-1:0]          raddr,
    output logic                                   wr_en,
    output logic [frce_pkg::AddrBits-1:0]          waddr
);

    localparam int SB = frce_pkg::SizeBits;

    frce_pkg::walk_ctl_t         job_reg;
    logic                        run_reg;
    logic [SB-1:0]               r_reg, c_reg;
    logic                        wv_reg;
    logic [frce_pkg::AddrBits-1:0] wa_reg;
    logic [SB-1:0]               sx, sy, dx, dy;
    logic                        sbank, dbank;
    logic                        last;

    always_comb begin
        sbank = job_reg.src_bank;
        dbank = ~job_reg.src_bank;
        dx = c_reg;
        dy = r_reg;
        case (job_reg.kind)
            frce_pkg::PASS_TURN_WHOLE: begin
                sx = SB'(job_reg.w - 1'b1 - r_reg);
                sy = c_reg;
            end
            frce_pkg::PASS_TURN_SUB: begin
                sx = SB'(job_reg.x1 + job_reg.w - 1'b1 - r_reg);
                sy = SB'(job_reg.y1 + c_reg);
            end
            frce_pkg::PASS_BACK_SUB: begin
                // job src_bank holds the scratch bank here
                sx = c_reg;
                sy = r_reg;
                dx = SB'(job_reg.x1 + c_reg);
                dy = SB'(job_reg.y1 + r_reg);
            end
            default: begin
                sx = SB'(job_reg.x1 + c_reg);
                sy = SB'(job_reg.y1 + r_reg);
            end
        endcase
        raddr = frce_pkg::addr_of(sbank, sx, sy);
        last  = (c_reg == SB'(job_reg.cols - 1'b1)) && (r_reg == SB'(job_reg.rows - 1'b1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            wv_reg  <= 1'b0;
        end else begin
            wv_reg <= run_reg;
            if (ctl.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && last) begin
                run_reg <= 1'b0;
            end
        end
        if (ctl.start) begin
            job_reg <= ctl;
            r_reg   <= '0;
            c_reg   <= '0;
        end else if (run_reg) begin
            if (c_reg == SB'(job_reg.cols - 1'b1)) begin
                c_reg <= '0;
                r_reg <= SB'(r_reg + 1'b1);
            end else begin
                c_reg <= SB'(c_reg + 1'b1);
            end
        end
        wa_reg <= frce_pkg::addr_of(dbank, dx, dy);
    end

    assign busy  = run_reg | wv_reg;
    assign wr_en = wv_reg;
    assign waddr = wa_reg;

endmodule

FILE: design/frame_rotate_crop_engine_unit.sv
// Frame rotate/crop engine: one command per transfer, one result per command.
// Load, select, select-all, write and every error answer are answered straight from
// the idle state; read passes through the read, read-data and output states (registered
// RAM read). Rotate and crop run copy passes through the single frame RAM port
// pair, one pixel per cycle: crop copies the selection once, whole-frame rotate runs k
// passes for k quarter turns, a square sub-selection rotate 2*k passes (turn into the
// other bank, then copy back). The block accepts no command while a command is in progress or
// its result waits.
module frame_rotate_crop_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic signed [9:0] s_x_first,
    input  logic signed [9:0] s_y_first,
    input  logic signed [9:0] s_x_second,
    input  logic signed [9:0] s_y_second,
    input  logic [23:0] s_pixel_in,
    input  logic signed [9:0] s_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [23:0] m_pixel_out,
    output logic [8:0]  m_sel_left,
    output logic [8:0]  m_sel_top,
    output logic [8:0]  m_sel_right,
    output logic [8:0]  m_sel_bottom,
    output logic [8:0]  m_frame_width,
    output logic [8:0]  m_frame_height
);

    localparam int SB = frce_pkg::SizeBits;
    localparam int AB = frce_pkg::AddrBits;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_RDATA = 6'b000100,
        S_PASS  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic          bank_reg, loaded_reg;
    logic [SB-1:0] w_reg, h_reg, l_reg, t_reg, r_reg, b_reg;
    logic [1:0]    turns_reg;
    logic          back_reg;      // next pass copies scratch back
    logic          is_crop_reg;
    logic [2:0]    st_reg;
    logic [23:0]   pout_reg;
    logic          mv_reg;
    logic [AB-1:0] rd_addr_reg;

    frce_pkg::walk_ctl_t ctl;
    logic          w_busy, w_we;
    logic [AB-1:0] w_raddr, w_waddr;
    logic          ram_we;
    logic [AB-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata;
    logic          px_we;

    frce_walker u_walk (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .busy(w_busy),
        .raddr(w_raddr), .wr_en(w_we), .waddr(w_waddr)
    );

    frce_ram #(.Width(frce_pkg::PixelBits), .Depth(frce_pkg::StoreDepth)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    wire accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !mv_reg;

    logic signed [9:0] lo_x, hi_x, lo_y, hi_y;
    logic          whole, pix_ok, sel_ok, square;
    logic [1:0]    turns;
    logic          ang_ok;
    logic [SB-1:0] sw, sh;

    always_comb begin
        lo_x = (s_x_first < s_x_second) ? s_x_first : s_x_second;
        hi_x = (s_x_first < s_x_second) ? s_x_second : s_x_first;
        lo_y = (s_y_first < s_y_second) ? s_y_first : s_y_second;
        hi_y = (s_y_first < s_y_second) ? s_y_second : s_y_first;
        sel_ok = !lo_x[9] && !lo_y[9] && (hi_x <= $signed({1'b0, w_reg}))
                 && (hi_y <= $signed({1'b0, h_reg})) && (lo_x != hi_x) && (lo_y != hi_y);
        pix_ok = !s_x_first[9] && !s_y_first[9]
                 && ({1'b0, s_x_first[8:0]} < {1'b0, w_reg})
                 && ({1'b0, s_y_first[8:0]} < {1'b0, h_reg});
        whole  = (l_reg == '0) && (t_reg == '0) && (r_reg == w_reg) && (b_reg == h_reg);
        sw     = SB'(r_reg - l_reg);
        sh     = SB'(b_reg - t_reg);
        square = (sw == sh);
        ang_ok = 1'b1;
        turns  = 2'd0;
        if (s_angle == 10'sd90 || s_angle == -10'sd270) begin
            turns = 2'd3;
        end else if (s_angle == -10'sd90 || s_angle == 10'sd270) begin
            turns = 2'd1;
        end else if (s_angle == 10'sd180 || s_angle == -10'sd180) begin
            turns = 2'd2;
        end else if (!(s_angle == 10'sd0 || s_angle == 10'sd360 || s_angle == -10'sd360)) begin
            ang_ok = 1'b0;
        end
    end

    // Launch a copy pass on a quarter turn, a copy back or a crop.
    logic          launch;
    always_comb begin
        ctl = '0;
        ctl.start = launch;
        ctl.x1 = l_reg;
        ctl.y1 = t_reg;
        if (is_crop_reg) begin
            ctl.kind = frce_pkg::PASS_CROP;
            ctl.src_bank = bank_reg;
            ctl.rows = sh;
            ctl.cols = sw;
        end else if (whole) begin
            ctl.kind = frce_pkg::PASS_TURN_WHOLE;
            ctl.src_bank = bank_reg;
            ctl.rows = w_reg;
            ctl.cols = h_reg;
            ctl.w = w_reg;
        end else if (back_reg) begin
            ctl.kind = frce_pkg::PASS_BACK_SUB;
            ctl.src_bank = ~bank_reg;
            ctl.rows = sw;
            ctl.cols = sw;
        end else begin
            ctl.kind = frce_pkg::PASS_TURN_SUB;
            ctl.src_bank = bank_reg;
            ctl.rows = sw;
            ctl.cols = sw;
            ctl.w = sw;
        end
    end

    assign launch = (state_reg == S_PASS);

    always_comb begin
        px_we     = accept && (s_cmd == frce_pkg::CMD_WRITE) && loaded_reg && pix_ok;
        ram_we    = px_we | w_we;
        ram_waddr = px_we ? frce_pkg::addr_of(bank_reg, SB'(s_x_first[8:0]),
                                              SB'(s_y_first[8:0])) : w_waddr;
        ram_raddr = (state_reg == S_READ) ? rd_addr_reg : w_raddr;
    end
    assign ram_wdata = px_we ? s_pixel_in : ram_rdata;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && loaded_reg) begin
                    if (s_cmd == frce_pkg::CMD_READ && pix_ok) begin
                        state_next = S_READ;
                    end else if (s_cmd == frce_pkg::CMD_ROTATE && ang_ok
                                 && turns != 2'd0 && (whole || square)) begin
                        state_next = S_PASS;
                    end else if (s_cmd == frce_pkg::CMD_CROP) begin
                        state_next = S_PASS;
                    end
                end
            end
            S_READ:  state_next = S_RDATA;
            S_RDATA: state_next = S_OUT;
            S_PASS:  state_next = S_WAIT;
            S_WAIT: begin
                if (!w_busy) begin
                    if (is_crop_reg) begin
                        state_next = S_OUT;
                    end else if (whole || back_reg) begin
                        state_next = (turns_reg == 2'd1) ? S_OUT : S_PASS;
                    end else begin
                        state_next = S_PASS;
                    end
                end
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            bank_reg   <= 1'b0;
            loaded_reg <= 1'b0;
            w_reg <= '0; h_reg <= '0;
            l_reg <= '0; t_reg <= '0; r_reg <= '0; b_reg <= '0;
            mv_reg <= 1'b0;
            turns_reg <= '0;
            back_reg <= 1'b0;
            is_crop_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        st_reg   <= frce_pkg::ST_OK;
                        pout_reg <= '0;
                        if (s_cmd == frce_pkg::CMD_LOAD) begin
                            if (s_x_second < 10'sd1 || s_x_second > 10'(frce_pkg::MaxSide)
                                || s_y_second < 10'sd1
                                || s_y_second > 10'(frce_pkg::MaxSide)) begin
                                st_reg <= frce_pkg::ST_BAD_COORD;
                            end else begin
                                w_reg <= SB'(s_x_second[8:0]);
                                h_reg <= SB'(s_y_second[8:0]);
                                loaded_reg <= 1'b1;
                                l_reg <= '0; t_reg <= '0;
                                r_reg <= SB'(s_x_second[8:0]);
                                b_reg <= SB'(s_y_second[8:0]);
                            end
                            mv_reg <= 1'b1;
                        end else if (s_cmd == frce_pkg::CMD_NONE) begin
                            mv_reg <= 1'b1;
                        end else if (!loaded_reg) begin
                            st_reg <= frce_pkg::ST_NO_IMAGE;
                            mv_reg <= 1'b1;
                        end else begin
                            case (s_cmd)
                                frce_pkg::CMD_WRITE: begin
                                    if (!pix_ok) st_reg <= frce_pkg::ST_BAD_COORD;
                                    mv_reg <= 1'b1;
                                end
                                frce_pkg::CMD_READ: begin
                                    if (!pix_ok) begin
                                        st_reg <= frce_pkg::ST_BAD_COORD;
                                        mv_reg <= 1'b1;
                                    end else begin
                                        rd_addr_reg <= frce_pkg::addr_of(bank_reg,
                                            SB'(s_x_first[8:0]), SB'(s_y_first[8:0]));
                                    end
                                end
                                frce_pkg::CMD_SELECT: begin
                                    if (!sel_ok) begin
                                        st_reg <= frce_pkg::ST_BAD_COORD;
                                    end else begin
                                        l_reg <= SB'(lo_x[8:0]);
                                        t_reg <= SB'(lo_y[8:0]);
                                        r_reg <= SB'(hi_x[8:0]);
                                        b_reg <= SB'(hi_y[8:0]);
                                    end
                                    mv_reg <= 1'b1;
                                end
                                frce_pkg::CMD_SELALL: begin
                                    l_reg <= '0; t_reg <= '0;
                                    r_reg <= w_reg; b_reg <= h_reg;
                                    mv_reg <= 1'b1;
                                end
                                frce_pkg::CMD_ROTATE: begin
                                    if (!ang_ok) begin
                                        st_reg <= frce_pkg::ST_BAD_ANGLE;
                                        mv_reg <= 1'b1;
                                    end else if (turns != 2'd0 && !whole && !square) begin
                                        st_reg <= frce_pkg::ST_NOT_SQUARE;
                                        mv_reg <= 1'b1;
                                    end else if (turns == 2'd0) begin
                                        mv_reg <= 1'b1;
                                    end else begin
                                        turns_reg   <= turns;
                                        back_reg    <= 1'b0;
                                        is_crop_reg <= 1'b0;
                                    end
                                end
                                frce_pkg::CMD_CROP: begin
                                    turns_reg   <= 2'd1;
                                    is_crop_reg <= 1'b1;
                                    back_reg    <= 1'b0;
                                end
                                default: mv_reg <= 1'b1;
                            endcase
                        end
                    end
                end
                S_RDATA: begin
                    pout_reg <= ram_rdata;
                end
                S_OUT: begin
                    mv_reg <= 1'b1;
                end
                S_WAIT: begin
                    if (!w_busy && !launch) begin
                        // finish one pass, then decide on the next
                        if (is_crop_reg) begin
                            bank_reg <= ~bank_reg;
                            w_reg <= sw; h_reg <= sh;
                            l_reg <= '0; t_reg <= '0; r_reg <= sw; b_reg <= sh;
                        end else if (whole) begin
                            bank_reg <= ~bank_reg;
                            w_reg <= h_reg; h_reg <= w_reg;
                            r_reg <= h_reg; b_reg <= w_reg;
                            turns_reg <= 2'(turns_reg - 1'b1);
                        end else if (!back_reg) begin
                            back_reg  <= 1'b1;
                        end else begin
                            back_reg  <= 1'b0;
                            turns_reg <= 2'(turns_reg - 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = mv_reg;
    assign m_status       = st_reg;
    assign m_pixel_out    = pout_reg;
    assign m_sel_left     = l_reg;
    assign m_sel_top      = t_reg;
    assign m_sel_right    = r_reg;
    assign m_sel_bottom   = b_reg;
    assign m_frame_width  = w_reg;
    assign m_frame_height = h_reg;

endmodule

FILE: design/frce_checker.sv
module frce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [23:0] m_pixel_out,
    input logic [8:0]  m_sel_right,
    input logic [8:0]  m_frame_width
);

    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");

    a_pix_zero_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != frce_pkg::ST_OK |-> m_pixel_out == 24'd0)
        else $error("pixel on error");

    a_sel_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sel_right <= m_frame_width) else $error("selection past frame");

endmodule

bind frame_rotate_crop_engine_unit frce_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_pixel_out(m_pixel_out), .m_sel_right(m_sel_right), .m_frame_width(m_frame_width)
);
